// File: design/sedc_pkg.sv
`timescale 1ns / 1ps

package sedc_pkg;

    // field widths
    localparam int POS_W  = 28;   // Q20.8 position
    localparam int DIFF_W = 29;   // difference of two positions
    localparam int DENS_W = 24;   // Q8.16 density
    localparam int RAD_W  = 20;
    localparam int RR_W   = 2 * RAD_W;
    localparam int SQ_W   = 58;   // product of two differences
    localparam int SUM_W  = 60;   // sum of three products
    localparam int ACC_W  = 96;   // quadratic accumulator
    localparam int LO_W   = 16;   // bisection lower bound
    localparam int MU_W   = 17;   // Q0.16 fraction, 0..65536
    localparam int NUM_W  = 42;   // signed division numerator
    localparam int MAG_W  = 41;   // numerator magnitude
    localparam int QUO_W  = 24;   // quotient bits before clamping

    localparam logic [MU_W-1:0] MU_ONE = 17'h10000;

    localparam logic signed [DENS_W-1:0] D_MAX = 24'sh7fffff;
    localparam logic signed [DENS_W-1:0] D_MIN = 24'sh800000;

    // side information carried alongside the division
    typedef struct packed {
        logic signed [DENS_W-1:0] dens_a;
        logic signed [DENS_W-1:0] dens_b;
        logic                     dug_a;
        logic                     dug_b;
        logic                     act_div;
        logic                     sel_first;
        logic                     flat_sat;
    } t_side;

    typedef struct packed {
        logic signed [DENS_W-1:0] new_first_density;
        logic signed [DENS_W-1:0] new_second_density;
        logic                     new_first_dug;
        logic                     new_second_dug;
        logic                     saturated;
    } t_result;

endpackage

// File: design/sedc_div.sv
`timescale 1ns / 1ps

module sedc_div
    import sedc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [MU_W-1:0]         i_den,
    input  t_side                   i_side,
    output logic                    o_valid,
    output t_result                 o_result
);

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MU_W-1:0]  den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             big;
        t_side            side;
    } t_dstage;

    t_dstage          r_st [0:QUO_W];
    logic [QUO_W:0]   r_v;
    logic             r_out_valid;
    t_result          r_result;

    logic             num_neg;
    logic [MAG_W-1:0] num_mag;
    logic [MAG_W-1:0] den_top;
    t_result          n_result;

    assign num_neg = i_num[NUM_W-1];
    assign num_mag = num_neg ? MAG_W'(-i_num) : MAG_W'(i_num);
    assign den_top = {i_den, {QUO_W{1'b0}}};

    // zero divisor or quotient of 2^24 and up saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem  <= num_mag;
            r_st[0].den  <= i_den;
            r_st[0].quo  <= '0;
            r_st[0].neg  <= num_neg;
            r_st[0].big  <= (i_den == '0) || (num_mag >= den_top);
            r_st[0].side <= i_side;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        localparam int BIT = QUO_W - 1 - j;
        logic [MAG_W-1:0] sub_den;
        logic [MAG_W:0]   trial;
        logic             take;
        t_dstage          n_st;

        assign sub_den = MAG_W'({{QUO_W{1'b0}}, r_st[j].den} << BIT);
        assign trial   = {1'b0, r_st[j].rem} - {1'b0, sub_den};
        assign take    = !trial[MAG_W] && !r_st[j].big;

        always_comb begin
            n_st = r_st[j];
            if (take) begin
                n_st.rem      = trial[MAG_W-1:0];
                n_st.quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j+1] <= n_st;
            end
        end
    end

    // sign, clamp and write-back to the chosen end
    always_comb begin
        t_dstage                  st;
        logic signed [DENS_W-1:0] val;
        logic                     sat;
        st  = r_st[QUO_W];
        val = D_MAX;
        sat = 1'b0;
        if (st.big) begin
            val = st.neg ? D_MIN : D_MAX;
            sat = 1'b1;
        end else if (st.neg) begin
            if (st.quo > 24'h800000) begin
                val = D_MIN;
                sat = 1'b1;
            end else begin
                val = -$signed(st.quo);
            end
        end else begin
            if (st.quo > 24'h7fffff) begin
                val = D_MAX;
                sat = 1'b1;
            end else begin
                val = $signed(st.quo);
            end
        end

        n_result.new_first_density  = st.side.dens_a;
        n_result.new_second_density = st.side.dens_b;
        n_result.new_first_dug      = st.side.dug_a;
        n_result.new_second_dug     = st.side.dug_b;
        n_result.saturated          = 1'b0;
        if (st.side.flat_sat) begin
            n_result.saturated = 1'b1;
        end else if (st.side.act_div) begin
            n_result.saturated = sat;
            if (st.side.sel_first) begin
                n_result.new_first_density = val;
                n_result.new_first_dug     = 1'b1;
            end else begin
                n_result.new_second_density = val;
                n_result.new_second_dug     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_v[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// File: design/sphere_edge_density_carve.sv
`timescale 1ns / 1ps
// throughput: one item per cycle while the skid entry is empty;
// every stage then takes a new item each cycle
// the 16 bisection stages and the 24-stage divider set the depth, not the rate
// a two-entry output (register plus skid) takes a result while another waits
// reset (synchronous, active low) empties the pipeline and clears all
// configuration registers to zero

module sphere_edge_density_carve
    import sedc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [27:0]  i_cfg_wdata,
    // edge items in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, first_density,
    // second_density, first_dug, second_dug, axis, zero fill
    input  logic [223:0] s_axis_tdata,
    // results out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_first_density, new_second_density, new_first_dug, new_second_dug,
    // saturated, zero fill
    output logic [55:0]  m_axis_tdata
);

    // register indexes
    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z = 3'd2;
    localparam logic [2:0] CFG_RADIUS   = 3'd3;
    localparam logic [2:0] CFG_ISO      = 3'd4;

    // edge axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam int NBIS = LO_W;

    // item data that rides through the front of the pipeline
    typedef struct packed {
        logic signed [DENS_W-1:0] dens_a;
        logic signed [DENS_W-1:0] dens_b;
        logic                     dug_a;
        logic                     dug_b;
        logic [1:0]               axis;
        logic                     flat;
        logic                     action;
    } t_pass;

    // bisection state: g(lo), slope at lo, |d|^2, lower bound
    typedef struct packed {
        logic signed [ACC_W-1:0] g;
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-1:0] a;
        logic [LO_W-1:0]         lo;
        logic                    in_a;
        t_pass                   pass;
    } t_bis;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [POS_W-1:0]  r_center [0:2];
    logic [RAD_W-1:0]         r_radius;
    logic signed [DENS_W-1:0] r_iso;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_radius    <= '0;
            r_iso       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CENTER_X: r_center[0] <= i_cfg_wdata;
                CFG_CENTER_Y: r_center[1] <= i_cfg_wdata;
                CFG_CENTER_Z: r_center[2] <= i_cfg_wdata;
                CFG_RADIUS:   r_radius    <= i_cfg_wdata[RAD_W-1:0];
                CFG_ISO:      r_iso       <= i_cfg_wdata[DENS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: the whole pipeline moves while the skid is empty
    // ---------------------------------------------------------------
    logic en;
    logic r_skid_valid;

    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    // input unpacking
    logic signed [POS_W-1:0] in_a [0:2];
    logic signed [POS_W-1:0] in_b [0:2];

    assign in_a[0] = s_axis_tdata[27:0];
    assign in_a[1] = s_axis_tdata[55:28];
    assign in_a[2] = s_axis_tdata[83:56];
    assign in_b[0] = s_axis_tdata[111:84];
    assign in_b[1] = s_axis_tdata[139:112];
    assign in_b[2] = s_axis_tdata[167:140];

    // ---------------------------------------------------------------
    // stage 1: offsets from the centre and the edge vector
    // f = first - c, d = second - first, e = second - c
    // ---------------------------------------------------------------
    logic                     r1_valid;
    logic signed [DIFF_W-1:0] r1_f [0:2];
    logic signed [DIFF_W-1:0] r1_d [0:2];
    logic signed [DIFF_W-1:0] r1_e [0:2];
    logic signed [DENS_W-1:0] r1_dens_a;
    logic signed [DENS_W-1:0] r1_dens_b;
    logic                     r1_dug_a;
    logic                     r1_dug_b;
    logic [1:0]               r1_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_f[k] <= DIFF_W'(in_a[k]) - DIFF_W'(r_center[k]);
                r1_d[k] <= DIFF_W'(in_b[k]) - DIFF_W'(in_a[k]);
                r1_e[k] <= DIFF_W'(in_b[k]) - DIFF_W'(r_center[k]);
            end
            r1_dens_a <= s_axis_tdata[191:168];
            r1_dens_b <= s_axis_tdata[215:192];
            r1_dug_a  <= s_axis_tdata[216];
            r1_dug_b  <= s_axis_tdata[217];
            r1_axis   <= s_axis_tdata[219:218];
        end
    end

    // ---------------------------------------------------------------
    // stage 2: products f.f, f.d, d.d, e.e per axis and radius squared
    // ---------------------------------------------------------------
    logic                   r2_valid;
    logic signed [SQ_W-1:0] r2_ff [0:2];
    logic signed [SQ_W-1:0] r2_fd [0:2];
    logic signed [SQ_W-1:0] r2_dd [0:2];
    logic signed [SQ_W-1:0] r2_ee [0:2];
    logic [RR_W-1:0]        r2_rr;
    t_pass                  r2_pass;
    logic                   n2_flat;

    // an edge with no extent along its own axis cannot be interpolated
    always_comb begin
        unique case (r1_axis)
            AXIS_X:    n2_flat = (r1_d[0] == '0);
            AXIS_Y:    n2_flat = (r1_d[1] == '0);
            AXIS_Z:    n2_flat = (r1_d[2] == '0);
            AXIS_NONE: n2_flat = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_ff[k] <= SQ_W'(r1_f[k]) * SQ_W'(r1_f[k]);
                r2_fd[k] <= SQ_W'(r1_f[k]) * SQ_W'(r1_d[k]);
                r2_dd[k] <= SQ_W'(r1_d[k]) * SQ_W'(r1_d[k]);
                r2_ee[k] <= SQ_W'(r1_e[k]) * SQ_W'(r1_e[k]);
            end
            r2_rr          <= RR_W'(r_radius) * RR_W'(r_radius);
            r2_pass.dens_a <= r1_dens_a;
            r2_pass.dens_b <= r1_dens_b;
            r2_pass.dug_a  <= r1_dug_a;
            r2_pass.dug_b  <= r1_dug_b;
            r2_pass.axis   <= r1_axis;
            r2_pass.flat   <= n2_flat;
            r2_pass.action <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: inside tests and the quadratic in t
    // g(t) = |d|^2 t^2 + 2^17 (f.d) t + 2^32 |f|^2 - 2^48 r^2
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] s3_a;
    logic signed [SUM_W-1:0] s3_b;
    logic signed [SUM_W-1:0] s3_cf;
    logic signed [SUM_W-1:0] s3_ce;
    logic [SUM_W-1:0]        s3_lim;
    logic                    s3_in_a;
    logic                    s3_in_b;
    logic                    s3_action;

    assign s3_a   = SUM_W'(r2_dd[0]) + SUM_W'(r2_dd[1]) + SUM_W'(r2_dd[2]);
    assign s3_b   = SUM_W'(r2_fd[0]) + SUM_W'(r2_fd[1]) + SUM_W'(r2_fd[2]);
    assign s3_cf  = SUM_W'(r2_ff[0]) + SUM_W'(r2_ff[1]) + SUM_W'(r2_ff[2]);
    assign s3_ce  = SUM_W'(r2_ee[0]) + SUM_W'(r2_ee[1]) + SUM_W'(r2_ee[2]);
    // (radius * 256)^2
    assign s3_lim = SUM_W'({r2_rr, 16'd0});

    // strictly inside
    assign s3_in_a   = $unsigned(s3_cf) < s3_lim;
    assign s3_in_b   = $unsigned(s3_ce) < s3_lim;
    // one end inside, some density below zero, and an end left to dig
    assign s3_action = (s3_in_a != s3_in_b)
                    && (r2_pass.dens_a[DENS_W-1] || r2_pass.dens_b[DENS_W-1])
                    && !(r2_pass.dug_a && r2_pass.dug_b);

    t_bis           r_bis [0:NBIS];
    logic [NBIS:0]  r_bv;
    t_bis           n_bis0;

    always_comb begin
        n_bis0.g           = (ACC_W'(s3_cf) << 32) - (ACC_W'(r2_rr) << 48);
        n_bis0.s           = ACC_W'(s3_b) << 17;
        n_bis0.a           = ACC_W'(s3_a);
        n_bis0.lo          = '0;
        n_bis0.in_a        = s3_in_a;
        n_bis0.pass        = r2_pass;
        n_bis0.pass.action = s3_action;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv[0] <= 1'b0;
        end else if (en) begin
            r_bv[0] <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bis[0] <= n_bis0;
        end
    end

    // ---------------------------------------------------------------
    // bisection: one bit of the crossing per stage, most significant first
    // g(lo + h) = g(lo) + h * slope(lo) + |d|^2 h^2, h a power of two,
    // so each stage is shifts and adds
    // ---------------------------------------------------------------
    for (genvar j = 0; j < NBIS; j++) begin : g_bis
        localparam int K = NBIS - 1 - j;
        logic signed [ACC_W-1:0] cand;
        logic                    outside;
        logic                    step;
        t_bis                    n_bis;

        assign cand    = r_bis[j].g + (r_bis[j].s <<< K) + (r_bis[j].a <<< (2 * K));
        assign outside = !cand[ACC_W-1];
        // first end inside: lo tracks the last point still inside
        assign step    = r_bis[j].in_a ? !outside : outside;

        always_comb begin
            n_bis = r_bis[j];
            if (step) begin
                n_bis.g     = cand;
                n_bis.s     = r_bis[j].s + (r_bis[j].a <<< (K + 1));
                n_bis.lo[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bv[j+1] <= 1'b0;
            end else if (en) begin
                r_bv[j+1] <= r_bv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_bis[j+1] <= n_bis;
            end
        end
    end

    // ---------------------------------------------------------------
    // crossing fraction and the divisor
    // ---------------------------------------------------------------
    t_bis                     bis_out;
    logic [MU_W-1:0]          nm_mu;
    logic                     nm_sel_first;
    logic [MU_W-1:0]          nm_m;
    t_side                    nm_side;

    logic                     rm_valid;
    logic [MU_W-1:0]          rm_m;
    logic [MU_W-1:0]          rm_den;
    logic signed [DENS_W-1:0] rm_other;
    t_side                    rm_side;

    assign bis_out      = r_bis[NBIS];
    assign nm_mu        = bis_out.in_a ? MU_W'(bis_out.lo) + MU_W'(1) : MU_W'(bis_out.lo);
    assign nm_sel_first = !bis_out.pass.dug_a;

    // no axis: the fraction is zero and the rewrite gives iso_level
    always_comb begin
        if (bis_out.pass.axis == AXIS_NONE) begin
            nm_m = '0;
        end else if (nm_sel_first) begin
            nm_m = nm_mu;
        end else begin
            nm_m = MU_ONE - nm_mu;
        end
    end

    always_comb begin
        nm_side.dens_a    = bis_out.pass.dens_a;
        nm_side.dens_b    = bis_out.pass.dens_b;
        nm_side.dug_a     = bis_out.pass.dug_a;
        nm_side.dug_b     = bis_out.pass.dug_b;
        nm_side.act_div   = bis_out.pass.action && !bis_out.pass.flat;
        nm_side.sel_first = nm_sel_first;
        nm_side.flat_sat  = bis_out.pass.action && bis_out.pass.flat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_valid <= 1'b0;
        end else if (en) begin
            rm_valid <= r_bv[NBIS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_m     <= nm_m;
            rm_den   <= MU_ONE - nm_m;
            rm_other <= nm_sel_first ? bis_out.pass.dens_b : bis_out.pass.dens_a;
            rm_side  <= nm_side;
        end
    end

    // ---------------------------------------------------------------
    // numerator: iso * 65536 - other density * fraction
    // ---------------------------------------------------------------
    logic                    rn_valid;
    logic signed [NUM_W-1:0] rn_num;
    logic [MU_W-1:0]         rn_den;
    t_side                   rn_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_valid <= 1'b0;
        end else if (en) begin
            rn_valid <= rm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rn_num  <= (NUM_W'(r_iso) <<< 16)
                     - NUM_W'(rm_other) * NUM_W'($signed({1'b0, rm_m}));
            rn_den  <= rm_den;
            rn_side <= rm_side;
        end
    end

    // ---------------------------------------------------------------
    // saturating divider and result assembly
    // ---------------------------------------------------------------
    logic    div_valid;
    t_result div_result;

    sedc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (rn_valid),
        .i_num    (rn_num),
        .i_den    (rn_den),
        .i_side   (rn_side),
        .o_valid  (div_valid),
        .o_result (div_result)
    );

    // ---------------------------------------------------------------
    // output register with skid entry
    // ---------------------------------------------------------------
    logic    r_out_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (div_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (div_valid) begin
            if (!r_out_valid || take) begin
                r_out <= div_result;
            end else begin
                r_skid <= div_result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.saturated, r_out.new_second_dug, r_out.new_first_dug,
                            r_out.new_second_density, r_out.new_first_density};

endmodule
